// File: hdl/pmd_pkg.sv
package pmd_pkg;

  // Fixed field widths
  localparam int GAIN_W      = 16;
  localparam int GAIN_FRAC   = 8;
  localparam int LIMIT_W     = 10;
  localparam int DB_W        = 8;
  localparam int SPEED_W     = 10;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_PROP   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_INTEG  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_DERIV  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_DRIVE_LIMIT = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_DEAD_BAND   = 3'd4;

  // Reset values
  localparam logic [GAIN_W-1:0]  GAIN_PROP_RST   = 16'd3840;
  localparam logic [GAIN_W-1:0]  GAIN_INTEG_RST  = 16'd128;
  localparam logic [GAIN_W-1:0]  GAIN_DERIV_RST  = 16'd128;
  localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST = 10'd1023;
  localparam logic [DB_W-1:0]    DEAD_BAND_RST   = 8'd10;

endpackage

// File: hdl/pid_position_motor_drive.sv
// PID position loop with a deadband, for a motor driver.
// Input stream: one request per control step carries target_angle and
// measured_angle. Output stream: one request per input carries drive_speed
// (0 = stop) and drive_forward (1 = forward). Inside the deadband the speed
// is 0 and the previous direction is repeated.
// Config port: cfg_we writes cfg_wdata into register cfg_addr (0 gain_prop,
// 1 gain_integ, 2 gain_deriv, 3 drive_limit, 4 dead_band); other indexes are
// dropped. Write only while no request is in flight.
// Pipeline: the edge that accepts the input captures the error and integral
// update, then come the multiply, term add, PID sum and magnitude/clamp
// stages before out_tvalid rises. Throughput: one request per cycle while
// out_tready keeps up; the only loop is the integral/last-error update,
// which is registered at the edge that accepts the request.
// Each stage moves on when the stage behind it is empty or moving, so empty
// stages keep taking input while a result waits on out_tready; a full
// pipeline behind a stalled output drops in_tready.
// Reset (rst_n low, synchronous) empties the pipeline, clears the integral,
// the last error and the held direction (backward), and restores the config registers.
module pid_position_motor_drive
  import pmd_pkg::*;
#(
  parameter int INTEGRAL_WIDTH = 24,
  parameter int ANGLE_WIDTH    = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // tdata: target_angle, measured_angle (low bits first), zero padded
  input  logic [((2*ANGLE_WIDTH+7)/8)*8-1:0]   in_tdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // tdata: drive_speed[9:0], drive_forward[10], zero padded
  output logic [OUT_TDATA_W-1:0]               out_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_we,
  input  logic [CFG_ADDR_W-1:0]                cfg_addr,
  input  logic [CFG_DATA_W-1:0]                cfg_wdata
);

  localparam int AW     = ANGLE_WIDTH;
  localparam int IW     = INTEGRAL_WIDTH;
  localparam int ERR_W  = AW + 1;
  localparam int DER_W  = AW + 2;
  localparam int XW     = ((IW > ERR_W) ? IW : ERR_W) + 1;
  // integral magnitude cap: beyond it the integral term dominates P+D
  localparam int MC_W   = AW + 20;
  localparam int MW     = (IW > MC_W) ? IW : MC_W;
  localparam int LO_W   = MC_W / 2;
  localparam int HI_W   = MC_W - LO_W;
  localparam int P_W    = GAIN_W + 1 + ERR_W;
  localparam int D_W    = GAIN_W + 1 + DER_W;
  localparam int PD_W   = D_W + 1;
  localparam int IM_W   = GAIN_W + MC_W;
  localparam int SUM_W  = IM_W + 2;
  localparam int CW     = (ERR_W > DB_W) ? ERR_W : DB_W;
  localparam int OPAD_W = OUT_TDATA_W - SPEED_W - 1;

  localparam logic signed [IW-1:0] IMAX    = {1'b0, {(IW-1){1'b1}}};
  localparam logic signed [IW-1:0] IMIN    = {1'b1, {(IW-1){1'b0}}};
  localparam logic [MW-1:0]        MAG_CAP = MW'(1) << (MC_W - 1);

  // Configuration registers
  logic [GAIN_W-1:0]  gain_prop_r, gain_integ_r, gain_deriv_r;
  logic [LIMIT_W-1:0] drive_limit_r;
  logic [DB_W-1:0]    dead_band_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_prop_r   <= GAIN_PROP_RST;
      gain_integ_r  <= GAIN_INTEG_RST;
      gain_deriv_r  <= GAIN_DERIV_RST;
      drive_limit_r <= DRIVE_LIMIT_RST;
      dead_band_r   <= DEAD_BAND_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_GAIN_PROP:   gain_prop_r   <= cfg_wdata;
        REG_GAIN_INTEG:  gain_integ_r  <= cfg_wdata;
        REG_GAIN_DERIV:  gain_deriv_r  <= cfg_wdata;
        REG_DRIVE_LIMIT: drive_limit_r <= cfg_wdata[LIMIT_W-1:0];
        REG_DEAD_BAND:   dead_band_r   <= cfg_wdata[DB_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage valids and enables: a stage loads when it is empty or its successor frees up
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic en1, en2, en3, en4, en_out, in_fire;

  assign en_out    = !out_valid_r || out_tready;
  assign en4       = !v4_r || en_out;
  assign en3       = !v3_r || en4;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1)    v1_r        <= in_fire;
      if (en2)    v2_r        <= v1_r;
      if (en3)    v3_r        <= v2_r;
      if (en4)    v4_r        <= v3_r;
      if (en_out) out_valid_r <= v4_r;
    end
  end

  // Stage 0: error, derivative, saturating integral, deadband test
  logic [AW-1:0]           target, measured;
  logic signed [ERR_W-1:0] err;
  logic signed [DER_W-1:0] deriv;
  logic signed [XW-1:0]    isum_x;
  logic signed [IW-1:0]    integral_r, integral_nxt;
  logic signed [ERR_W-1:0] last_err_r;
  logic [IW-1:0]           isum_mag;
  logic [MW-1:0]           isum_mag_w;
  logic [MC_W-1:0]         isum_cap;
  logic [ERR_W-1:0]        err_mag;
  logic                    out_band;

  always_comb begin
    target   = in_tdata[AW-1:0];
    measured = in_tdata[2*AW-1:AW];
    err      = $signed({1'b0, target}) - $signed({1'b0, measured});
    deriv    = DER_W'(err) - DER_W'(last_err_r);
    isum_x   = XW'(integral_r) + XW'(err);
    if (isum_x > XW'(IMAX))      integral_nxt = IMAX;
    else if (isum_x < XW'(IMIN)) integral_nxt = IMIN;
    else                         integral_nxt = isum_x[IW-1:0];
    isum_mag   = integral_nxt[IW-1] ? IW'(-integral_nxt) : IW'(integral_nxt);
    isum_mag_w = MW'(isum_mag);
    isum_cap   = (isum_mag_w > MAG_CAP) ? MAG_CAP[MC_W-1:0] : isum_mag_w[MC_W-1:0];
    err_mag    = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    out_band   = CW'(err_mag) > CW'(dead_band_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r <= '0;
      last_err_r <= '0;
    end else if (in_fire) begin
      integral_r <= integral_nxt;
      last_err_r <= err;
    end
  end

  logic signed [ERR_W-1:0] s1_err_r;
  logic signed [DER_W-1:0] s1_deriv_r;
  logic [MC_W-1:0]         s1_imag_r;
  logic                    s1_ineg_r, s1_band_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_err_r   <= err;
      s1_deriv_r <= deriv;
      s1_imag_r  <= isum_cap;
      s1_ineg_r  <= integral_nxt[IW-1];
      s1_band_r  <= out_band;
    end
  end

  // Stage 1: gain products, integral term split in two halves
  logic signed [P_W-1:0]   s2_p_r;
  logic signed [D_W-1:0]   s2_d_r;
  logic [GAIN_W+LO_W-1:0]  s2_ilo_r;
  logic [GAIN_W+HI_W-1:0]  s2_ihi_r;
  logic                    s2_ineg_r, s2_band_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_p_r    <= $signed({1'b0, gain_prop_r}) * s1_err_r;
      s2_d_r    <= $signed({1'b0, gain_deriv_r}) * s1_deriv_r;
      s2_ilo_r  <= gain_integ_r * s1_imag_r[LO_W-1:0];
      s2_ihi_r  <= gain_integ_r * s1_imag_r[MC_W-1:LO_W];
      s2_ineg_r <= s1_ineg_r;
      s2_band_r <= s1_band_r;
    end
  end

  // Stage 2: P+D and recombined integral term
  logic signed [PD_W-1:0] s3_pd_r;
  logic [IM_W-1:0]        s3_imag_r;
  logic                   s3_ineg_r, s3_band_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_pd_r   <= PD_W'(s2_p_r) + PD_W'(s2_d_r);
      s3_imag_r <= (IM_W'(s2_ihi_r) << LO_W) + IM_W'(s2_ilo_r);
      s3_ineg_r <= s2_ineg_r;
      s3_band_r <= s2_band_r;
    end
  end

  // Stage 3: PID sum, integral term signed as the integral
  logic signed [SUM_W-1:0] s4_sum_r;
  logic                    s4_band_r;

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_sum_r  <= s3_ineg_r ? SUM_W'(s3_pd_r) - $signed(SUM_W'(s3_imag_r))
                             : SUM_W'(s3_pd_r) + $signed(SUM_W'(s3_imag_r));
      s4_band_r <= s3_band_r;
    end
  end

  // Stage 4: magnitude, drop fraction, clamp, direction
  logic [SUM_W-1:0]   sum_mag, sum_int;
  logic [SPEED_W-1:0] omag;
  logic               ctrl_pos;
  logic [SPEED_W-1:0] out_speed_r;
  logic               out_fwd_r, last_dir_r;

  always_comb begin
    sum_mag  = s4_sum_r[SUM_W-1] ? SUM_W'(-s4_sum_r) : SUM_W'(s4_sum_r);
    sum_int  = sum_mag >> GAIN_FRAC;
    omag     = (sum_int > SUM_W'(drive_limit_r)) ? SPEED_W'(drive_limit_r)
                                                 : sum_int[SPEED_W-1:0];
    ctrl_pos = !s4_sum_r[SUM_W-1] && (omag != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_dir_r <= 1'b0;
    end else if (en_out && v4_r && s4_band_r) begin
      last_dir_r <= ctrl_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && v4_r) begin
      out_speed_r <= s4_band_r ? omag : '0;
      out_fwd_r   <= s4_band_r ? ctrl_pos : last_dir_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OPAD_W{1'b0}}, out_fwd_r, out_speed_r};

  // Checks
  a_speed_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_speed_r <= drive_limit_r)
    else $error("drive_speed above drive_limit");

  a_deadband_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (en_out && v4_r && !s4_band_r) |=> out_speed_r == '0)
    else $error("nonzero speed inside deadband");

  a_moving_dir_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_speed_r != '0) |-> out_fwd_r == last_dir_r)
    else $error("held direction differs from last moving request");

  a_full_pipe_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && v3_r && v4_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input accepted into a full stalled pipeline");

endmodule
